// ===== rtl/tccw_pkg.sv =====
// shared types and constants for the text console cell writer
`default_nettype none

package tccw_pkg;

    // item payload widths
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_W      = 8;
    localparam int CELL_W     = 16;

    // result field widths
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int POS_OUT_W = 11;

    // character and attribute constants
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    // operation codes, codes 5 to 7 do nothing
    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_COPY  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        WR_NONE      = 3'd0,
        WR_ITEM      = 3'd1,
        WR_COPY      = 3'd2,
        WR_FILL_INIT = 3'd3,
        WR_FILL      = 3'd4,
        WR_SCROLL    = 3'd5
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_NONE        = 2'd0,
        RD_SRC         = 2'd1,
        RD_SCROLL_HEAD = 2'd2,
        RD_SCROLL_NEXT = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    exec;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        logic    sweep_clr;
        logic    sweep_inc;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       need_scroll;
        logic       copy_ok;
        logic       sweep_last;
        logic       out_free;
        logic       status_bit;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_cell_writer_core.sv =====
// top level of the text console cell writer: controller, datapath and checks
// sequence: an item is taken in idle; in execute, write, set, unknown ops, a put that
//   does not scroll and an off-screen copy hand their result over; a valid copy reads
//   its source and writes it in the copy state; clear sweeps all ROWS*COLUMNS cells; a
//   put that scrolls primes a read, then sweeps the store; one item at a time
// reset: synchronous active low aresetn, cursor homes, then an init pass over all
//   ROWS*COLUMNS cells blanks the store while s_axis_tready stays low
`default_nettype none

module text_console_cell_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input items
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // character [7:0], row [15:8], col [23:16], src_row [31:24], src_col [39:32],
    // color [47:40]
    input  wire logic [tccw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation [2:0]
    input  wire logic [tccw_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // result items
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // cursor_row [4:0], cursor_col [11:5], cursor_pos [22:12], status [23]
    output logic      [tccw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // default color register
    input  wire logic                               cfg_we,
    input  wire logic [tccw_pkg::CFG_W-1:0]         cfg_wdata
);

    import tccw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller walks init, exec, copy, scroll and clear phases
    tccw_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // datapath holds the item, cursor, screen store and output register
    tccw_dpath #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts)
    );

    // one item at a time: an accepted item closes the input until it is done
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after an accept");

    // the store must be blanked before the first item goes in
    a_init_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("input open right after reset");

    // an ignored status only comes from ops that take a position
    a_status_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && sts.status_bit) |-> (sts.op == OP_WRITE || sts.op == OP_COPY))
        else $error("status set by an op without a position");

    // a result is loaded only into a free output register
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a waiting one");

endmodule

`default_nettype wire

// ===== rtl/tccw_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tccw_ctrl.sv =====
// sequencing state machine for the console cell writer
`default_nettype none

module tccw_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire tccw_pkg::sts_t sts,
    output tccw_pkg::cmd_t      cmd
);

    import tccw_pkg::*;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_COPY   = 8'b0000_1000,
        S_PRIME  = 8'b0001_0000,
        S_SCROLL = 8'b0010_0000,
        S_CLEAR  = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        done          = 1'b0;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.wr_sel    = WR_NONE;
        cmd.rd_sel    = RD_NONE;
        cmd.sweep_clr = 1'b0;
        cmd.sweep_inc = 1'b0;
        cmd.out_load  = 1'b0;

        case (state_reg)
            S_INIT: begin
                cmd.wr_sel    = WR_FILL_INIT;
                cmd.sweep_inc = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec      = 1'b1;
                cmd.wr_sel    = WR_ITEM;
                cmd.sweep_clr = 1'b1;
                case (sts.op)
                    OP_PUT: begin
                        if (sts.need_scroll) begin
                            state_next = S_PRIME;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    OP_COPY: begin
                        if (sts.copy_ok) begin
                            cmd.rd_sel = RD_SRC;
                            state_next = S_COPY;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        state_next = S_CLEAR;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            S_COPY: begin
                cmd.wr_sel = WR_COPY;
                done       = 1'b1;
            end
            S_PRIME: begin
                cmd.rd_sel = RD_SCROLL_HEAD;
                state_next = S_SCROLL;
            end
            S_SCROLL: begin
                cmd.wr_sel    = WR_SCROLL;
                cmd.rd_sel    = RD_SCROLL_NEXT;
                cmd.sweep_inc = 1'b1;
                done          = sts.sweep_last;
            end
            S_CLEAR: begin
                cmd.wr_sel    = WR_FILL;
                cmd.sweep_inc = 1'b1;
                done          = sts.sweep_last;
            end
            S_RESULT: begin
                done = 1'b1;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result over, or park until the output register frees up
        if (done) begin
            if (sts.out_free) begin
                cmd.out_load = 1'b1;
                state_next   = S_IDLE;
            end else begin
                state_next = S_RESULT;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tccw_dpath.sv =====
// cursor, screen store and result register of the console cell writer
`default_nettype none

module tccw_dpath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [tccw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic [tccw_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [tccw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [tccw_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire tccw_pkg::cmd_t                     cmd,
    output tccw_pkg::sts_t                          sts
);

    import tccw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    // item registers
    logic [2:0]        op_reg;
    logic [7:0]        ch_reg;
    logic signed [7:0] r_reg;
    logic signed [7:0] c_reg;
    logic signed [7:0] sr_reg;
    logic signed [7:0] sc_reg;
    logic [7:0]        color_reg;

    logic [CFG_W-1:0]  dcolor_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ADDR_W-1:0] sweep_reg;
    logic [ADDR_W-1:0] sweep_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic              dst_ok;
    logic              src_ok;
    logic              newline;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    put_row_t;
    logic [COL_W-1:0]  put_col;
    logic              need_scroll;
    logic [ROW_W-1:0]  set_row;
    logic [COL_W-1:0]  set_col;
    logic              status_bit;
    logic              out_free;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;
    logic [31:0]       pos_ext;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // position checks and addresses
    assign dst_ok = !r_reg[7] && (r_reg[6:0] < 7'(ROWS)) &&
                    !c_reg[7] && (c_reg[6:0] < 7'(COLUMNS));
    assign src_ok = !sr_reg[7] && (sr_reg[6:0] < 7'(ROWS)) &&
                    !sc_reg[7] && (sc_reg[6:0] < 7'(COLUMNS));
    assign dst_addr = ADDR_W'(r_reg[6:0]) * ADDR_W'(COLUMNS) + ADDR_W'(c_reg[6:0]);
    assign src_addr = ADDR_W'(sr_reg[6:0]) * ADDR_W'(COLUMNS) + ADDR_W'(sc_reg[6:0]);
    assign cur_addr = ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);

    // cursor advance for put at cursor
    assign newline = (ch_reg == NEWLINE_CHAR);
    assign row_inc = {1'b0, cur_row_reg} + (ROW_W+1)'(1);
    assign col_inc = {1'b0, cur_col_reg} + (COL_W+1)'(1);

    always_comb begin
        if (newline || (col_inc >= (COL_W+1)'(COLUMNS))) begin
            put_col   = '0;
            put_row_t = row_inc;
        end else begin
            put_col   = col_inc[COL_W-1:0];
            put_row_t = {1'b0, cur_row_reg};
        end
    end

    assign need_scroll = (put_row_t >= (ROW_W+1)'(ROWS));

    // clamp for set cursor
    always_comb begin
        if (r_reg[7]) begin
            set_row = '0;
        end else if (r_reg[6:0] >= 7'(ROWS)) begin
            set_row = ROW_W'(ROWS - 1);
        end else begin
            set_row = ROW_W'(r_reg[6:0]);
        end
        if (c_reg[7]) begin
            set_col = '0;
        end else if (c_reg[6:0] >= 7'(COLUMNS)) begin
            set_col = COL_W'(COLUMNS - 1);
        end else begin
            set_col = COL_W'(c_reg[6:0]);
        end
    end

    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (cmd.exec) begin
            case (op_reg)
                OP_PUT: begin
                    cur_col_next = put_col;
                    cur_row_next = need_scroll ? ROW_W'(ROWS - 1) : put_row_t[ROW_W-1:0];
                end
                OP_SET: begin
                    cur_row_next = set_row;
                    cur_col_next = set_col;
                end
                OP_CLEAR: begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                end
                default: begin
                    cur_row_next = cur_row_reg;
                    cur_col_next = cur_col_reg;
                end
            endcase
        end
    end

    assign status_bit = ((op_reg == OP_WRITE) && !dst_ok) ||
                        ((op_reg == OP_COPY) && !(dst_ok && src_ok));

    // sweep counter for reset fill, clear and scroll
    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.sweep_clr) begin
            sweep_next = '0;
        end else if (cmd.sweep_inc) begin
            sweep_next = sweep_reg + ADDR_W'(1);
        end
    end

    // store write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = {dcolor_reg, BLANK_CHAR};
        case (cmd.wr_sel)
            WR_ITEM: begin
                if (op_reg == OP_PUT && !newline) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_addr;
                    ram_wdata = {dcolor_reg, ch_reg};
                end else if (op_reg == OP_WRITE && dst_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_addr;
                    ram_wdata = {color_reg, ch_reg};
                end
            end
            WR_COPY: begin
                ram_we    = 1'b1;
                ram_waddr = dst_addr;
                ram_wdata = ram_rdata;
            end
            WR_FILL_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {RESET_COLOR, BLANK_CHAR};
            end
            WR_FILL: begin
                ram_we = 1'b1;
            end
            WR_SCROLL: begin
                ram_we = 1'b1;
                if (sweep_reg < ADDR_W'(CELLS - COLUMNS)) begin
                    ram_wdata = ram_rdata;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // store read port, scroll reads run one row ahead of the writes
    always_comb begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        case (cmd.rd_sel)
            RD_SRC: begin
                ram_raddr = src_addr;
            end
            RD_SCROLL_HEAD: begin
                ram_raddr = ADDR_W'(COLUMNS);
            end
            RD_SCROLL_NEXT: begin
                if (sweep_reg < ADDR_W'(CELLS - COLUMNS - 1)) begin
                    ram_raddr = sweep_reg + ADDR_W'(COLUMNS + 1);
                end
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    tccw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_screen (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // result fields, masked to their widths
    assign row_ext = 32'(cur_row_next);
    assign col_ext = 32'(cur_col_next);
    assign pos_ext = row_ext * 32'(COLUMNS) + col_ext;

    assign out_free     = !m_valid_reg || m_axis_tready;
    assign m_valid_next = cmd.out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            dcolor_reg  <= RESET_COLOR;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                dcolor_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= s_axis_tuser;
            ch_reg    <= s_axis_tdata[7:0];
            r_reg     <= s_axis_tdata[15:8];
            c_reg     <= s_axis_tdata[23:16];
            sr_reg    <= s_axis_tdata[31:24];
            sc_reg    <= s_axis_tdata[39:32];
            color_reg <= s_axis_tdata[47:40];
        end
        if (cmd.out_load) begin
            m_data_reg <= {status_bit, pos_ext[POS_OUT_W-1:0],
                           col_ext[COL_OUT_W-1:0], row_ext[ROW_OUT_W-1:0]};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign sts.op          = op_reg;
    assign sts.need_scroll = need_scroll;
    assign sts.copy_ok     = dst_ok && src_ok;
    assign sts.sweep_last  = (sweep_reg == ADDR_W'(CELLS - 1));
    assign sts.out_free    = out_free;
    assign sts.status_bit  = status_bit;

endmodule

`default_nettype wire

// ===== test/tb_text_console_cell_writer_core.sv =====
// testbench for the text console cell writer: cursor prediction and stream checking
`timescale 1ns / 100ps

module tb_text_console_cell_writer_core;
    import tccw_pkg::*;

    // screen geometry, kept equal to the block's defaults
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // operation codes that the block ignores
    localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

    // stimulus shaping
    localparam int IDLE_PCT     = 14;     // chance per cycle of a gap or a stall
    localparam int PHASE_ITEMS  = 500;    // random items per color setting
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int TAIL_CYCLES  = 8;      // settle time once every result is back
    localparam int WATCHDOG_MAX = 20000;  // covers the init pass, a scroll and the hold-off
    localparam int MAX_REPORTS  = 40;

    // one result item, laid out as m_axis_tdata
    typedef struct packed {
        logic                 status;
        logic [POS_OUT_W-1:0] pos;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
    } cursor_report_t;

    // keeps its own screen, cursor and color; predicts a cursor report per item
    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        int                cur_row;
        int                cur_col;
        logic [7:0]        attr;
        cursor_report_t    expected_q [$];
        int                errors;
        int                n_items;
        int                n_results;
        int                n_scrolls;
        int                n_ignored;
        int                n_clears;

        function new();
            attr    = RESET_COLOR;
            cur_row = 0;
            cur_col = 0;
            errors  = 0;
            n_items = 0;
            n_results = 0;
            n_scrolls = 0;
            n_ignored = 0;
            n_clears  = 0;
            blank_rows(0, ROWS);
        endfunction

        function void blank_rows(int first, int last);
            for (int i = first * COLUMNS; i < last * COLUMNS; i++)
                cells[i] = {attr, BLANK_CHAR};
        endfunction

        function bit on_screen(int r, int c);
            return r >= 0 && r < ROWS && c >= 0 && c < COLUMNS;
        endfunction

        function void set_color(logic [7:0] value);
            attr = value;
        endfunction

        // an item went into the block: update the shadow state, queue the report
        function void note_item(logic [2:0] op, logic [7:0] ch, logic [7:0] row_in,
                                logic [7:0] col_in, logic [7:0] srow_in,
                                logic [7:0] scol_in, logic [7:0] color);
            int             r;
            int             c;
            int             sr;
            int             sc;
            logic           ignored;
            cursor_report_t rep;
            r  = int'($signed(row_in));
            c  = int'($signed(col_in));
            sr = int'($signed(srow_in));
            sc = int'($signed(scol_in));
            ignored = 1'b0;
            n_items++;
            case (op)
                OP_PUT: begin
                    if (ch == NEWLINE_CHAR) begin
                        cur_col = 0;
                        cur_row++;
                    end else begin
                        cells[cur_row * COLUMNS + cur_col] = {attr, ch};
                        cur_col++;
                        if (cur_col >= COLUMNS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                    if (cur_row >= ROWS) begin
                        for (int i = 0; i + COLUMNS < CELLS; i++)
                            cells[i] = cells[i + COLUMNS];
                        blank_rows(ROWS - 1, ROWS);
                        cur_row = ROWS - 1;
                        n_scrolls++;
                    end
                end
                OP_WRITE: begin
                    if (on_screen(r, c))
                        cells[r * COLUMNS + c] = {color, ch};
                    else
                        ignored = 1'b1;
                end
                OP_SET: begin
                    cur_row = (r < 0) ? 0 : (r >= ROWS) ? ROWS - 1 : r;
                    cur_col = (c < 0) ? 0 : (c >= COLUMNS) ? COLUMNS - 1 : c;
                end
                OP_COPY: begin
                    if (on_screen(sr, sc) && on_screen(r, c))
                        cells[r * COLUMNS + c] = cells[sr * COLUMNS + sc];
                    else
                        ignored = 1'b1;
                end
                OP_CLEAR: begin
                    blank_rows(0, ROWS);
                    cur_row = 0;
                    cur_col = 0;
                    n_clears++;
                end
                default: begin
                end
            endcase
            if (ignored)
                n_ignored++;
            rep.row    = ROW_OUT_W'(cur_row);
            rep.col    = COL_OUT_W'(cur_col);
            rep.pos    = POS_OUT_W'(cur_row * COLUMNS + cur_col);
            rep.status = ignored;
            expected_q.push_back(rep);
        endfunction

        function void report_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
            end
        endfunction

        // a result item left the block: compare it with the oldest report
        function void check_result(logic [OUT_DATA_W-1:0] data);
            cursor_report_t got;
            cursor_report_t want;
            got = cursor_report_t'(data);
            n_results++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result %h arrived with none expected, expected nothing",
                             $time, data);
                return;
            end
            want = expected_q.pop_front();
            report_field("cursor_row", want.row, got.row);
            report_field("cursor_col", want.col, got.col);
            report_field("cursor_pos", want.pos, got.pos);
            report_field("status", want.status, got.status);
        endfunction
    endclass

    // clock and synchronous reset
    logic aclk = 1'b0;
    logic aresetn;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // block ports
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // character, row, col, src_row, src_col, color
    logic [IN_USER_W-1:0]  s_axis_tuser;   // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // cursor_row, cursor_col, cursor_pos, status
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;

    text_console_cell_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    console_scoreboard console = new();

    // idling controls, each written by the main sequence only
    bit tx_gaps_on  = 1'b1;
    bit rx_stall_on = 1'b1;
    bit hold_phase  = 1'b0;
    // written by the receiver process only
    bit hold_done   = 1'b0;

    // receiver: random stalls, or none, plus one long hold-off counted here
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_phase && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_done = 1'b1;
            end else if (rx_stall_on) begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // results: valid and ready are stable from the falling edge up to the
    // rising edge that takes the item, so they are sampled in between
    always @(negedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            console.check_result(m_axis_tdata);
    end

    // watchdog: cycles with no item taken on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_MAX) begin
            @(negedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_MAX, console.expected_q.size());
        $display("text_console_cell_writer_core: mismatch");
        $finish;
    end

    // offer one operation and wait for the block to take it
    task automatic send_op(input logic [2:0] op, input logic [7:0] ch,
                           input logic [7:0] row, input logic [7:0] col,
                           input logic [7:0] srow, input logic [7:0] scol,
                           input logic [7:0] color);
        logic ready_seen;
        // random gaps before the item; valid stays high between back-to-back items
        if (tx_gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {color, scol, srow, col, row, ch};
        s_axis_tuser  <= op;
        do begin
            @(negedge aclk);
            ready_seen = s_axis_tready;
            @(posedge aclk);
        end while (!ready_seen);
        console.note_item(op, ch, row, col, srow, scol, color);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (console.expected_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // default color write, only with the block idle
    task automatic write_color(input logic [7:0] value);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        console.set_color(value);
    endtask

    // coordinate: mostly on screen, some at the borders, some any byte
    function automatic logic [7:0] pick_coord(int lim);
        int sel;
        sel = $urandom_range(9);
        if (sel < 7)
            return 8'($urandom_range(lim - 1, 0));
        if (sel == 7) begin
            case ($urandom_range(2))
                0: return '1;
                1: return 8'(lim - 1);
                default: return 8'(lim);
            endcase
        end
        return 8'($urandom_range(255, 0));
    endfunction

    // weighted random operation; puts dominate so the cursor walks and scrolls
    task automatic send_random_op();
        int         pick;
        logic [2:0] op;
        logic [7:0] ch;
        pick = $urandom_range(99);
        ch   = 8'($urandom_range(255, 0));
        if (pick < 40) begin
            op = OP_PUT;
            if ($urandom_range(5) == 0)
                ch = NEWLINE_CHAR;
        end else if (pick < 58) begin
            op = OP_WRITE;
        end else if (pick < 70) begin
            op = OP_SET;
        end else if (pick < 96) begin
            op = OP_COPY;
        end else if (pick < 97) begin
            op = OP_CLEAR;
        end else begin
            op = 3'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
        end
        send_op(op, ch, pick_coord(ROWS), pick_coord(COLUMNS), pick_coord(ROWS),
                pick_coord(COLUMNS), 8'($urandom_range(255, 0)));
    endtask

    // main sequence
    initial begin
        logic [7:0] phase_color [4];
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PUT;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset color, plain puts, then the border cases
        send_op(OP_PUT, 8'h41, 0, 0, 0, 0, 0);
        send_op(OP_PUT, 8'h00, 0, 0, 0, 0, 0);
        send_op(OP_PUT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_op(OP_PUT, NEWLINE_CHAR, 0, 0, 0, 0, 0);
        // write at position: last cell, first cell, then off the screen by row or by column
        send_op(OP_WRITE, 8'h55, 8'(ROWS - 1), 8'(COLUMNS - 1), 0, 0, 8'haa);
        send_op(OP_WRITE, 8'hff, 0, 0, 0, 0, 8'hff);
        send_op(OP_WRITE, 8'h31, 8'hff, 0, 0, 0, 8'h12);
        send_op(OP_WRITE, 8'h32, 0, 8'(COLUMNS), 0, 0, 8'h34);
        send_op(OP_WRITE, 8'h33, 8'(ROWS), 0, 0, 0, 8'h56);
        send_op(OP_WRITE, 8'h34, 8'h80, 8'h7f, 0, 0, 8'h78);
        // set cursor clamps at both ends; the put after it wraps the row
        send_op(OP_SET, 0, 8'h80, 8'h7f, 0, 0, 0);
        send_op(OP_PUT, 8'h78, 0, 0, 0, 0, 0);
        // newline on the last row scrolls
        send_op(OP_SET, 0, 8'h7f, 8'h80, 0, 0, 0);
        send_op(OP_PUT, NEWLINE_CHAR, 0, 0, 0, 0, 0);
        // a put in the last cell wraps and scrolls
        send_op(OP_SET, 0, 8'(ROWS - 1), 8'(COLUMNS - 1), 0, 0, 0);
        send_op(OP_PUT, 8'h7a, 0, 0, 0, 0, 0);
        // copy: valid, then source or destination off the screen
        send_op(OP_COPY, 0, 8'(ROWS - 1), 8'(COLUMNS - 1), 0, 0, 0);
        send_op(OP_COPY, 0, 0, 0, 8'(ROWS), 0, 0);
        send_op(OP_COPY, 0, 0, 8'hff, 1, 1, 0);
        send_op(OP_COPY, 0, 1, 1, 8'h7f, 8'(COLUMNS), 0);
        send_op(OP_SET, 0, 8'(ROWS), 8'(COLUMNS), 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        // unused opcodes report the cursor untouched
        send_op(OP_UNKNOWN_LO, 8'h41, 3, 3, 3, 3, 3);
        send_op(OP_UNKNOWN_LO + 3'd1, 8'h41, 3, 3, 3, 3, 3);
        send_op(OP_UNKNOWN_HI, 8'h41, 3, 3, 3, 3, 3);

        // random phases, each under its own default color
        phase_color[0] = 8'($urandom_range(255, 0));
        phase_color[1] = 8'h00;
        phase_color[2] = 8'hff;
        phase_color[3] = RESET_COLOR;
        for (int ph = 0; ph < 4; ph++) begin
            write_color(phase_color[ph]);
            // phase 1 runs flat out on both sides
            tx_gaps_on  = (ph != 1);
            rx_stall_on = (ph != 1);
            // phase 2 opens with the receiver holding off while items keep coming
            if (ph == 2)
                hold_phase = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_op();
        end

        drain_block();
        $display("covered %0d items and %0d results over four color settings",
                 console.n_items, console.n_results);
        $display("scrolls %0d, clears %0d, ignored out-of-range ops %0d",
                 console.n_scrolls, console.n_clears, console.n_ignored);
        if (console.errors == 0 && console.expected_q.size() == 0)
            $display("text_console_cell_writer_core: match");
        else
            $display("text_console_cell_writer_core: mismatch");
        $finish;
    end

endmodule
